// ----- sv/fsdith_pkg.sv -----
// Shared types, constants and helpers for the Floyd-Steinberg RGB222 dither.
// No dependencies; imported by fsdith_chan and the top level.
`default_nettype none

package fsdith_pkg;

  // Configuration port.
  localparam int CfgW    = 11;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 1'b1;
  localparam logic [CfgW-1:0]    FrameSizeReset = 11'd1024;

  // Default frame limits.
  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 1024;

  // Number formats: errors and adjusted values carry four fraction bits.
  localparam int NumChan  = 3;
  localparam int FracBits = 4;
  localparam int ErrW     = 11;
  localparam int FxW      = 14;
  localparam int ClampW   = 12;
  localparam int ProdW    = 14;
  localparam logic [ClampW-1:0] FxMax = 12'd4080;

  // Quantizer thresholds on the integer channel value and the level step.
  localparam logic [7:0] Thr1      = 8'd43;
  localparam logic [7:0] Thr2      = 8'd128;
  localparam logic [7:0] Thr3      = 8'd213;
  localparam logic [7:0] LevelStep = 8'd85;

  // Diffusion weights in sixteenths.
  localparam int WeightRight      = 7;
  localparam int WeightBelowLeft  = 3;
  localparam int WeightBelow      = 5;
  localparam int WeightBelowRight = 1;

  typedef logic signed [ErrW-1:0] err_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [5:0] colour_code;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_done;
  } pix_out_t;

  // Per-channel result of the quantizer: level and the four error shares.
  typedef struct packed {
    logic [1:0] level;
    err_t       e_right;
    err_t       e_below_left;
    err_t       e_below;
    err_t       e_below_right;
  } chan_res_t;

  function automatic logic [7:0] level_to_val(input logic [1:0] lvl);
    return {6'b000000, lvl} * LevelStep;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fsdith_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fsdith_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the contents before a write to the same address in that cycle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/fsdith_chan.sv -----
// One color channel of the dither: error add, clamp, quantize, error shares.
// Depends on fsdith_pkg.
`default_nettype none

module fsdith_chan (
  input  wire logic [7:0]            pix_i,
  input  wire fsdith_pkg::err_t      carry_i,
  input  wire fsdith_pkg::err_t      above_i,
  output fsdith_pkg::chan_res_t      res_o
);
  import fsdith_pkg::*;

  logic signed [FxW-1:0]   fx;
  logic [ClampW-1:0]       fx_clamped;
  logic [7:0]              val;
  logic [1:0]              level;
  logic signed [ClampW:0]  err_wide;
  logic signed [ProdW-1:0] err_ext;
  logic signed [ProdW-1:0] prod_right;
  logic signed [ProdW-1:0] prod_below_left;
  logic signed [ProdW-1:0] prod_below;

  always_comb begin
    fx = $signed({2'b00, pix_i, 4'b0000}) + FxW'(carry_i) + FxW'(above_i);

    if (fx < 0) begin
      fx_clamped = '0;
    end else if (fx > $signed({2'b00, FxMax})) begin
      fx_clamped = FxMax;
    end else begin
      fx_clamped = fx[ClampW-1:0];
    end

    // Truncate to the integer value and pick the nearest level.
    val = fx_clamped[ClampW-1:FracBits];
    if (val >= Thr3) begin
      level = 2'd3;
    end else if (val >= Thr2) begin
      level = 2'd2;
    end else if (val >= Thr1) begin
      level = 2'd1;
    end else begin
      level = 2'd0;
    end

    err_wide = $signed({1'b0, fx_clamped}) - $signed({1'b0, level_to_val(level), 4'b0000});
    err_ext  = ProdW'(err_wide);

    prod_right      = err_ext * ProdW'(WeightRight);
    prod_below_left = err_ext * ProdW'(WeightBelowLeft);
    prod_below      = err_ext * ProdW'(WeightBelow);

    // Arithmetic shifts give floor division by sixteen.
    res_o.level         = level;
    res_o.e_right       = ErrW'(prod_right >>> FracBits);
    res_o.e_below_left  = ErrW'(prod_below_left >>> FracBits);
    res_o.e_below       = ErrW'(prod_below >>> FracBits);
    res_o.e_below_right = ErrW'((err_ext * ProdW'(WeightBelowRight)) >>> FracBits);
  end

endmodule

`default_nettype wire

// ----- sv/floyd_steinberg_rgb222_dither.sv -----
// Top level of the Floyd-Steinberg RGB222 dither.
// Depends on fsdith_pkg, fsdith_chan and fsdith_ram.
`default_nettype none

// The block takes one 24-bit RGB pixel per clock in raster order and returns one
// RGB222 result per pixel: the packed 6-bit code, the expanded color (level
// times 85) and a flag on the last pixel of the frame. Throughput is one pixel
// per clock with no gaps between rows or frames while the output is not stalled.
// An input transaction loads the working register, and the result moves on to the
// output register once that register is free or is emptied in the same cycle. The
// result waits in the output register until it is taken. The next input is taken
// while a result waits, as long as the working register is free or moves on in
// the same cycle. The per-column error for the next row lives in a line buffer
// with one write and one registered read port, MaxWidth entries of 33 bits; each
// pixel reads its column on acceptance and, but for the first of a row, writes
// the column to its left when processed. The error for the last column of a row
// is parked in a register and written in the first free write slot, which at the
// latest is the first pixel of the next row. The line buffer needs no clearing
// after reset, since the first row ignores what it reads. Frame width and height
// are set through the configuration port; the user must write them only while the
// block is idle, which the block itself does not enforce. A size of zero counts
// as one and a size above the limit counts as the limit.
module floyd_steinberg_rgb222_dither #(
  parameter int MaxWidth  = fsdith_pkg::DefMaxWidth,
  parameter int MaxHeight = fsdith_pkg::DefMaxHeight
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration writes.
  input  wire logic                           cfg_we_i,
  input  wire logic [fsdith_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fsdith_pkg::CfgW-1:0]    cfg_data_i,
  // Pixel input.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire fsdith_pkg::pix_in_t            in_pix_i,
  // Dithered output.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output fsdith_pkg::pix_out_t                out_pix_o
);
  import fsdith_pkg::*;

  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int RamW = NumChan * ErrW;

  // Configuration registers.
  logic [CfgW-1:0] frame_width_q;
  logic [CfgW-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameSizeReset;
      frame_height_q <= FrameSizeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFrameWidth:  frame_width_q  <= cfg_data_i;
        CfgFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Index of the last column and last row after the size limits are applied.
  logic [CfgW-1:0] width_m1;
  logic [CfgW-1:0] height_m1;
  logic [ColW-1:0] col_last;
  logic [RowW-1:0] row_last;

  always_comb begin
    width_m1  = frame_width_q - CfgW'(1);
    height_m1 = frame_height_q - CfgW'(1);

    if (frame_width_q == '0) begin
      col_last = '0;
    end else if (32'(frame_width_q) > MaxWidth) begin
      col_last = ColW'(MaxWidth - 1);
    end else begin
      col_last = ColW'(width_m1);
    end

    if (frame_height_q == '0) begin
      row_last = '0;
    end else if (32'(frame_height_q) > MaxHeight) begin
      row_last = RowW'(MaxHeight - 1);
    end else begin
      row_last = RowW'(height_m1);
    end
  end

  // Handshakes. The working stage fires when the output register can take its result.
  logic b_valid_q;
  logic out_valid_q;
  logic b_fire;
  logic in_fire;

  assign b_fire      = b_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !b_valid_q || b_fire;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Position of the accepted pixel. A counter beyond a shrunk size is pulled back
  // to the last column or row.
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] a_x;
  logic [RowW-1:0] a_y;
  logic            a_last_col;
  logic            a_last_row;

  always_comb begin
    a_x        = (col_q >= col_last) ? col_last : col_q;
    a_y        = (row_q >= row_last) ? row_last : row_q;
    a_last_col = (a_x == col_last);
    a_last_row = (a_y == row_last);

    if (a_last_col) begin
      col_d = '0;
      row_d = a_last_row ? '0 : a_y + RowW'(1);
    end else begin
      col_d = a_x + ColW'(1);
      row_d = a_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Working stage registers.
  pix_in_t         b_pix_q;
  logic [ColW-1:0] b_x_q;
  logic            b_last_col_q;
  logic            b_last_row_q;
  logic            b_above_en_q;
  logic            b_byp_en_q;
  logic [RamW-1:0] b_byp_q;

  // Neighbor error state, per channel.
  err_t carry_q [NumChan];
  err_t bps0_q  [NumChan];
  err_t bps1_q  [NumChan];

  // Last-column error waiting for a free write slot.
  logic            tail_pend_q;
  logic [ColW-1:0] tail_addr_q;
  logic [RamW-1:0] tail_data_q;

  // Line buffer.
  logic            ram_we;
  logic [ColW-1:0] ram_waddr;
  logic [RamW-1:0] ram_wdata;
  logic [RamW-1:0] ram_rdata;

  // Channel datapath.
  logic [7:0]      chan_pix   [NumChan];
  err_t            chan_above [NumChan];
  chan_res_t       chan_res   [NumChan];
  logic [RamW-1:0] wr_word;
  logic [RamW-1:0] tail_word;
  logic [RamW-1:0] above_word;

  assign chan_pix[0] = b_pix_q.in_red;
  assign chan_pix[1] = b_pix_q.in_green;
  assign chan_pix[2] = b_pix_q.in_blue;

  // The error from above comes from the line buffer, or from the bypass register
  // when the entry was still being written at the time of the read.
  assign above_word = b_byp_en_q ? b_byp_q : ram_rdata;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      chan_above[c] = b_above_en_q ? err_t'(above_word[c*ErrW +: ErrW]) : '0;
      wr_word[c*ErrW +: ErrW]   = bps1_q[c] + chan_res[c].e_below_left;
      tail_word[c*ErrW +: ErrW] = bps0_q[c] + chan_res[c].e_below;
    end
  end

  for (genvar g = 0; g < NumChan; g++) begin : g_chan
    fsdith_chan u_chan (
      .pix_i   (chan_pix[g]),
      .carry_i (carry_q[g]),
      .above_i (chan_above[g]),
      .res_o   (chan_res[g])
    );
  end

  // The processed pixel writes the column to its left; otherwise the parked
  // last-column error uses the port.
  logic cw_en;

  assign cw_en     = b_fire && (b_x_q != '0);
  assign ram_we    = cw_en || tail_pend_q;
  assign ram_waddr = cw_en ? b_x_q - ColW'(1) : tail_addr_q;
  assign ram_wdata = cw_en ? wr_word : tail_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '{default: '0};
      bps0_q  <= '{default: '0};
      bps1_q  <= '{default: '0};
    end else if (b_fire) begin
      for (int c = 0; c < NumChan; c++) begin
        carry_q[c] <= b_last_col_q ? '0 : chan_res[c].e_right;
        bps1_q[c]  <= b_last_col_q ? '0 : err_t'(tail_word[c*ErrW +: ErrW]);
        bps0_q[c]  <= b_last_col_q ? '0 : chan_res[c].e_below_right;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_pend_q <= 1'b0;
    end else if (b_fire && b_last_col_q) begin
      tail_pend_q <= 1'b1;
    end else if (!cw_en) begin
      tail_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && b_last_col_q) begin
      tail_addr_q <= b_x_q;
      tail_data_q <= tail_word;
    end
  end

  fsdith_ram #(
    .Width (RamW),
    .Depth (MaxWidth)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (a_x),
    .rdata_o (ram_rdata)
  );

  // Writes that land in the read cycle or later are caught here and forwarded.
  logic hit_w;
  logic hit_tn;
  logic hit_to;

  assign hit_w  = cw_en && ((b_x_q - ColW'(1)) == a_x);
  assign hit_tn = b_fire && b_last_col_q && (b_x_q == a_x);
  assign hit_to = tail_pend_q && (tail_addr_q == a_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (in_fire) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_pix_q      <= in_pix_i;
      b_x_q        <= a_x;
      b_last_col_q <= a_last_col;
      b_last_row_q <= a_last_row;
      b_above_en_q <= (a_y != '0);
      b_byp_en_q   <= hit_w || hit_tn || hit_to;
      if (hit_w) begin
        b_byp_q <= wr_word;
      end else if (hit_tn) begin
        b_byp_q <= tail_word;
      end else begin
        b_byp_q <= tail_data_q;
      end
    end
  end

  // Output register.
  pix_out_t out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_pix_q.colour_code <= {chan_res[0].level, chan_res[1].level, chan_res[2].level};
      out_pix_q.out_red     <= level_to_val(chan_res[0].level);
      out_pix_q.out_green   <= level_to_val(chan_res[1].level);
      out_pix_q.out_blue    <= level_to_val(chan_res[2].level);
      out_pix_q.frame_done  <= b_last_col_q && b_last_row_q;
    end
  end

  assign out_pix_o = out_pix_q;

`ifndef ASSERT_OFF
  // A parked last-column error must have drained before another pixel writes.
  a_tail_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_en |-> !tail_pend_q)
    else $error("line buffer write while last-column error still parked");

  // At most one source feeds the bypass register.
  a_byp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> $onehot0({hit_w, hit_tn || hit_to}))
    else $error("conflicting line buffer forwarding sources");

  // The last pixel of a frame sends the position back to the origin.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && a_last_col && a_last_row |=> col_q == '0 && row_q == '0)
    else $error("position counters did not wrap at end of frame");
`endif

endmodule

`default_nettype wire
